>>> hdl/tcw_pkg.sv
// Shared types, constants and glyph helpers for the text console writer.
// No dependencies; every other file of the block refers to this package.
package tcw_pkg;

   // Default console geometry
   localparam int COLUMNS_DEFAULT = 40;
   localparam int ROWS_DEFAULT    = 25;

   // Field widths
   localparam int OP_W        = 2;
   localparam int VALUE_W     = 32;
   localparam int GLYPH_W     = 8;
   localparam int COLOR_W     = 4;
   localparam int COL_FIELD_W = 6;
   localparam int ROW_FIELD_W = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_PAD_W   = RSP_TDATA_W - COL_FIELD_W - ROW_FIELD_W - GLYPH_W - 2 * COLOR_W;

   // Number formatting
   localparam int DIGIT_W    = 4;
   localparam int DEC_DIGITS = 10;
   localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
   localparam int BCD_W      = DEC_DIGITS * DIGIT_W;

   // Operation codes
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_CHAR = 2'd0;
   localparam op_type OP_HEX  = 2'd1;
   localparam op_type OP_DEC  = 2'd2;

   // Result kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FOREGROUND = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = 1'b1;

   localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd15;
   localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

   // Character codes
   localparam logic [GLYPH_W-1:0] CHR_BS    = 8'd8;
   localparam logic [GLYPH_W-1:0] CHR_LF    = 8'd10;
   localparam logic [GLYPH_W-1:0] CHR_CR    = 8'd13;
   localparam logic [GLYPH_W-1:0] CHR_SPACE = 8'd32;
   localparam logic [GLYPH_W-1:0] CHR_TILDE = 8'd126;
   localparam logic [GLYPH_W-1:0] CHR_DEL   = 8'd127;
   localparam logic [GLYPH_W-1:0] CHR_ZERO  = 8'h30;
   localparam logic [GLYPH_W-1:0] CHR_UPPER_A = 8'h41;
   localparam logic [GLYPH_W-1:0] CHR_LOWER_X = 8'h78;

   // One character on its way to the cursor unit
   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic               last;
   } byte_item_type;

   // Current cell colors
   typedef struct packed {
      logic [COLOR_W-1:0] foreground;
      logic [COLOR_W-1:0] background;
   } colors_type;

   // One result item
   typedef struct packed {
      logic                   kind;
      logic [COL_FIELD_W-1:0] column;
      logic [ROW_FIELD_W-1:0] row;
      logic [GLYPH_W-1:0]     glyph;
      logic [COLOR_W-1:0]     foreground;
      logic [COLOR_W-1:0]     background;
      logic                   last;
   } rsp_item_type;

   // Uppercase hex digit
   function automatic logic [GLYPH_W-1:0] hex_glyph(input logic [DIGIT_W-1:0] nib);
      logic [GLYPH_W-1:0] wide;
      wide = GLYPH_W'(nib);
      if (nib < 4'd10) begin
         hex_glyph = CHR_ZERO + wide;
      end else begin
         hex_glyph = CHR_UPPER_A + wide - 8'd10;
      end
   endfunction

   // Decimal digit
   function automatic logic [GLYPH_W-1:0] dec_glyph(input logic [DIGIT_W-1:0] digit);
      dec_glyph = CHR_ZERO + GLYPH_W'(digit);
   endfunction

endpackage

>>> hdl/text_console_writer.sv
// Top level of the text console writer: request sequencer, color registers,
// and the decimal converter and cursor unit below it.
// Depends on tcw_pkg, tcw_bcd and tcw_cursor.
//
//  channel  direction  handshake            payload
//  req_     in         req_tvalid/tready    tuser operation, tdata value
//  rsp_     out        rsp_tvalid/tready    tuser kind, tlast last, tdata cell
//  csr_     in         csr_valid/ready      csr_index register, csr_data color
//
// Each emitted character passes the cursor unit, which queues a clear after the
// cell write when the character also causes one. Decimal adds a bit-serial
// conversion and then drops leading zeros. One request is worked at a time.
// Reset puts the cursor at row 0, column 0 and colors at white on black.
// A stalled rsp_ side holds the cursor unit, which holds the sequencer.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tcw_pkg::VALUE_W-1:0]         req_tdata,   // value[31:0]
   input  logic [tcw_pkg::OP_W-1:0]            req_tuser,   // operation[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // column[5:0], row[10:6], glyph[18:11], foreground[22:19],
   // background[26:23], zero[31:27]
   output logic [tcw_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,   // kind[0]
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tcw_pkg::COLOR_W-1:0]         csr_data
);

   localparam int HEX_CNT_W = $clog2(tcw_pkg::HEX_DIGITS);
   localparam int VALUE_W   = tcw_pkg::VALUE_W;
   localparam int DIGIT_W   = tcw_pkg::DIGIT_W;

   typedef enum logic [2:0] {T_IDLE, T_CHAR, T_PFX_ZERO, T_PFX_X, T_HEX, T_DEC} seq_state_type;

   seq_state_type                state_ff, state_in;
   logic [tcw_pkg::GLYPH_W-1:0]  char_ff, char_in;
   logic [VALUE_W-1:0]           hex_ff, hex_in;
   logic [HEX_CNT_W-1:0]         hex_cnt_ff, hex_cnt_in;
   tcw_pkg::colors_type          colors_ff, colors_in;

   logic                         take_req;
   logic                         dec_start;
   logic                         digit_valid;
   logic                         digit_ready;
   logic [DIGIT_W-1:0]           digit;
   logic                         digit_last;
   logic                         byte_valid;
   logic                         byte_ready;
   tcw_pkg::byte_item_type       byte_item;
   logic                         take_byte;
   tcw_pkg::rsp_item_type        rsp_item;

   assign req_tready  = (state_ff == T_IDLE);
   assign take_req    = req_tvalid && req_tready;
   assign dec_start   = take_req && (req_tuser == tcw_pkg::OP_DEC);
   assign csr_ready   = 1'b1;
   assign take_byte   = byte_valid && byte_ready;
   assign digit_ready = (state_ff == T_DEC) && byte_ready;

   // Pick the next character for the cursor unit
   always_comb begin
      byte_valid = 1'b0;
      byte_item  = '0;
      unique case (state_ff)
         T_IDLE: begin
            byte_valid = 1'b0;
         end
         T_CHAR: begin
            byte_valid      = 1'b1;
            byte_item.glyph = char_ff;
            byte_item.last  = 1'b1;
         end
         T_PFX_ZERO: begin
            byte_valid      = 1'b1;
            byte_item.glyph = tcw_pkg::CHR_ZERO;
         end
         T_PFX_X: begin
            byte_valid      = 1'b1;
            byte_item.glyph = tcw_pkg::CHR_LOWER_X;
         end
         T_HEX: begin
            byte_valid      = 1'b1;
            byte_item.glyph = tcw_pkg::hex_glyph(hex_ff[VALUE_W-1 -: DIGIT_W]);
            byte_item.last  = (hex_cnt_ff == HEX_CNT_W'(tcw_pkg::HEX_DIGITS - 1));
         end
         T_DEC: begin
            byte_valid      = digit_valid;
            byte_item.glyph = tcw_pkg::dec_glyph(digit);
            byte_item.last  = digit_last;
         end
         default: byte_valid = 1'b0;
      endcase
   end

   // Sequencer and color registers
   always_comb begin
      state_in   = state_ff;
      char_in    = char_ff;
      hex_in     = hex_ff;
      hex_cnt_in = hex_cnt_ff;
      colors_in  = colors_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tcw_pkg::CSR_FOREGROUND: colors_in.foreground = csr_data;
            tcw_pkg::CSR_BACKGROUND: colors_in.background = csr_data;
            default: colors_in = colors_ff;
         endcase
      end
      unique case (state_ff)
         T_IDLE: begin
            if (take_req) begin
               char_in    = req_tdata[tcw_pkg::GLYPH_W-1:0];
               hex_in     = req_tdata;
               hex_cnt_in = '0;
               case (req_tuser)
                  tcw_pkg::OP_CHAR: state_in = T_CHAR;
                  tcw_pkg::OP_HEX:  state_in = T_PFX_ZERO;
                  tcw_pkg::OP_DEC:  state_in = T_DEC;
                  default:          state_in = T_IDLE;
               endcase
            end
         end
         T_CHAR: begin
            if (take_byte) state_in = T_IDLE;
         end
         T_PFX_ZERO: begin
            if (take_byte) state_in = T_PFX_X;
         end
         T_PFX_X: begin
            if (take_byte) state_in = T_HEX;
         end
         T_HEX: begin
            if (take_byte) begin
               hex_in     = {hex_ff[VALUE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               hex_cnt_in = hex_cnt_ff + HEX_CNT_W'(1);
               if (byte_item.last) state_in = T_IDLE;
            end
         end
         T_DEC: begin
            if (take_byte && byte_item.last) state_in = T_IDLE;
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= T_IDLE;
         hex_cnt_ff           <= '0;
         colors_ff.foreground <= tcw_pkg::FOREGROUND_RESET;
         colors_ff.background <= tcw_pkg::BACKGROUND_RESET;
      end else begin
         state_ff   <= state_in;
         hex_cnt_ff <= hex_cnt_in;
         colors_ff  <= colors_in;
      end
      char_ff <= char_in;
      hex_ff  <= hex_in;
   end

   tcw_bcd u_bcd (
      .clock       (clock),
      .reset       (reset),
      .start       (dec_start),
      .start_value (req_tdata),
      .digit_valid (digit_valid),
      .digit_ready (digit_ready),
      .digit       (digit),
      .digit_last  (digit_last)
   );

   tcw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_ready (byte_ready),
      .byte_item  (byte_item),
      .colors     (colors_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Pack the result item onto the stream
   assign rsp_tdata = {{tcw_pkg::RSP_PAD_W{1'b0}}, rsp_item.background, rsp_item.foreground,
                       rsp_item.glyph, rsp_item.row, rsp_item.column};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

endmodule

>>> hdl/tcw_bcd.sv
// Binary to decimal converter: shift-add-3 over the 32 value bits, one bit per
// cycle, then hands out the digits most significant first without leading zeros.
// Depends on tcw_pkg.
module tcw_bcd (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tcw_pkg::VALUE_W-1:0]     start_value,
   output logic                            digit_valid,
   input  logic                            digit_ready,
   output logic [tcw_pkg::DIGIT_W-1:0]     digit,
   output logic                            digit_last
);

   localparam int BIT_CNT_W = $clog2(tcw_pkg::VALUE_W + 1);
   localparam int DIG_CNT_W = $clog2(tcw_pkg::DEC_DIGITS + 1);
   localparam int BCD_W     = tcw_pkg::BCD_W;
   localparam int DIGIT_W   = tcw_pkg::DIGIT_W;

   typedef enum logic [1:0] {B_IDLE, B_CONV, B_SKIP, B_EMIT} bcd_state_type;

   bcd_state_type                  state_ff, state_in;
   logic [tcw_pkg::VALUE_W-1:0]    bin_ff, bin_in;
   logic [BCD_W-1:0]               bcd_ff, bcd_in;
   logic [BCD_W-1:0]               bcd_adj;
   logic [BIT_CNT_W-1:0]           bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]           dig_cnt_ff, dig_cnt_in;
   logic [DIGIT_W-1:0]             top_digit;

   assign top_digit   = bcd_ff[BCD_W-1 -: DIGIT_W];
   assign digit       = top_digit;
   assign digit_valid = (state_ff == B_EMIT);
   assign digit_last  = (dig_cnt_ff == DIG_CNT_W'(1));

   // Add three to every digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < tcw_pkg::DEC_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W];
         end
      end
   end

   // Sequence: convert, drop leading zeros, emit
   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               bin_in     = start_value;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(tcw_pkg::VALUE_W);
               state_in   = B_CONV;
            end
         end
         B_CONV: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[tcw_pkg::VALUE_W-1]};
            bin_in     = {bin_ff[tcw_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               dig_cnt_in = DIG_CNT_W'(tcw_pkg::DEC_DIGITS);
               state_in   = B_SKIP;
            end
         end
         B_SKIP: begin
            // keep at least one digit so that zero prints as "0"
            if (top_digit == '0 && dig_cnt_ff != DIG_CNT_W'(1)) begin
               bcd_in     = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            end else begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (digit_ready) begin
               bcd_in     = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
               if (digit_last) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   // Conversion never runs past its last bit
   a_conv_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_CONV |-> bit_cnt_ff != '0)
      else $error("converter bit count ran out");

   // Digit count stays within the ten decimal places while emitting
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_EMIT |-> (dig_cnt_ff != '0 &&
                              dig_cnt_ff <= DIG_CNT_W'(tcw_pkg::DEC_DIGITS)))
      else $error("digit count out of range");

   // Every emitted digit is a proper decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      digit_valid |-> digit <= 4'd9)
      else $error("non-decimal digit emitted");

endmodule

>>> hdl/tcw_cursor.sv
// Cursor unit: takes one character at a time, moves the cursor and queues the
// cell write and clear-screen items it causes into a registered output slot.
// Depends on tcw_pkg.
module tcw_cursor #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   output logic                   byte_ready,
   input  tcw_pkg::byte_item_type byte_item,
   input  tcw_pkg::colors_type    colors,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tcw_pkg::rsp_item_type  rsp_item
);

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   logic [COL_W-1:0]             col_ff, col_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic                         clr_pend_ff, clr_pend_in;
   logic                         last_pend_ff, last_pend_in;
   logic [COL_W-1:0]             wr_col_ff, wr_col_in;
   logic [ROW_W-1:0]             wr_row_ff, wr_row_in;
   logic [tcw_pkg::GLYPH_W-1:0]  wr_glyph_ff, wr_glyph_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_item_type        rsp_item_ff, rsp_item_in;
   logic                         take_byte;
   logic                         out_free;
   logic [tcw_pkg::GLYPH_W-1:0]  b;

   assign byte_ready = !wr_pend_ff && !clr_pend_ff;
   assign take_byte  = byte_valid && byte_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign b          = byte_item.glyph;

   // Decode the character and step the cursor
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      wr_pend_in   = wr_pend_ff;
      clr_pend_in  = clr_pend_ff;
      last_pend_in = last_pend_ff;
      wr_col_in    = wr_col_ff;
      wr_row_in    = wr_row_ff;
      wr_glyph_in  = wr_glyph_ff;
      if (take_byte) begin
         last_pend_in = byte_item.last;
         case (b) inside
            tcw_pkg::CHR_LF, tcw_pkg::CHR_CR: begin
               col_in = '0;
               if (row_ff == LAST_ROW) begin
                  row_in      = '0;
                  clr_pend_in = 1'b1;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
            tcw_pkg::CHR_BS, tcw_pkg::CHR_DEL: begin
               // step back, wrapping to the end of the previous row
               if (col_ff != '0) begin
                  col_in = col_ff - COL_W'(1);
               end else if (row_ff != '0) begin
                  row_in = row_ff - ROW_W'(1);
                  col_in = LAST_COL;
               end
               wr_pend_in  = 1'b1;
               wr_col_in   = col_in;
               wr_row_in   = row_in;
               wr_glyph_in = tcw_pkg::CHR_SPACE;
            end
            default: begin
               if (b >= tcw_pkg::CHR_SPACE && b <= tcw_pkg::CHR_TILDE) begin
                  wr_pend_in  = 1'b1;
                  wr_col_in   = col_ff;
                  wr_row_in   = row_ff;
                  wr_glyph_in = b;
                  if (col_ff == LAST_COL) begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        row_in      = '0;
                        clr_pend_in = 1'b1;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end else begin
                     col_in = col_ff + COL_W'(1);
                  end
               end
            end
         endcase
      end

      // Move a queued item into the output slot, the write before the clear
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (out_free && wr_pend_ff) begin
         rsp_valid_in           = 1'b1;
         rsp_item_in.kind       = tcw_pkg::KIND_WRITE;
         rsp_item_in.column     = tcw_pkg::COL_FIELD_W'(wr_col_ff);
         rsp_item_in.row        = tcw_pkg::ROW_FIELD_W'(wr_row_ff);
         rsp_item_in.glyph      = wr_glyph_ff;
         rsp_item_in.foreground = colors.foreground;
         rsp_item_in.background = colors.background;
         rsp_item_in.last       = last_pend_ff && !clr_pend_ff;
         wr_pend_in             = 1'b0;
      end else if (out_free && clr_pend_ff) begin
         rsp_valid_in      = 1'b1;
         rsp_item_in       = '0;
         rsp_item_in.kind  = tcw_pkg::KIND_CLEAR;
         rsp_item_in.last  = last_pend_ff;
         clr_pend_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         wr_pend_ff   <= wr_pend_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_pend_ff <= last_pend_in;
      wr_col_ff    <= wr_col_in;
      wr_row_ff    <= wr_row_in;
      wr_glyph_ff  <= wr_glyph_in;
      rsp_item_ff  <= rsp_item_in;
   end

   // Cursor column stays on the screen
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= LAST_COL)
      else $error("cursor column past last column");

   // Cursor row stays on the screen
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= LAST_ROW)
      else $error("cursor row past last row");

   // A queued clear always leaves the cursor at the top row
   a_clear_top: assert property (@(posedge clock) disable iff (reset)
      clr_pend_ff |-> row_ff == '0)
      else $error("clear queued with cursor off the top row");

endmodule
